// File: rtl/sstf_pkg.sv
// ---------------------------------------------------------------------------
// SSTF scheduler package
// Shared constants and types for the shortest-seek-first disk scheduler.
// ---------------------------------------------------------------------------
package sstf_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int CYL_BITS     = 16;
   localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
   localparam int SEEK_BITS    = 22;
   localparam int OUT_CYL_BITS = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [SEEK_BITS-1:0] SEEK_MAX = {SEEK_BITS{1'b1}};

   // register index, taken from paddr[2]
   localparam logic REG_START_HEAD = 1'b0;

   typedef struct packed {
      logic [CYL_BITS-1:0] cyl;
      logic [IDX_BITS-1:0] idx;
      logic                live;
   } cell_data_type;

   typedef struct packed {
      logic                shift;
      logic                mark;
      logic                clear;
      logic [IDX_BITS-1:0] mark_idx;
   } cell_ctl_type;

   typedef struct packed {
      logic                found;
      logic [CYL_BITS-1:0] distance;
      logic [IDX_BITS-1:0] idx;
      logic [CYL_BITS-1:0] cyl;
   } best_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_PICK   = 3'b100
   } state_type;

endpackage

// File: rtl/sstf_req_if.sv
// ---------------------------------------------------------------------------
// SSTF request channel
// Valid/ready channel carrying one cylinder request per transaction.
// ---------------------------------------------------------------------------
interface sstf_req_if;
   logic                              valid;
   logic                              ready;
   logic [sstf_pkg::OUT_CYL_BITS-1:0] cylinder;
   logic                              last;

   modport source (output valid, output cylinder, output last, input ready);
   modport sink   (input valid, input cylinder, input last, output ready);
endinterface

// File: rtl/sstf_rsp_if.sv
// ---------------------------------------------------------------------------
// SSTF result channel
// Valid/ready channel carrying one served request per transaction.
// ---------------------------------------------------------------------------
interface sstf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sstf_pkg::OUT_CYL_BITS-1:0] served_cylinder;
   logic [sstf_pkg::OUT_CYL_BITS-1:0] move_distance;
   logic [sstf_pkg::SEEK_BITS-1:0]    total_seek;
   logic                              overflow;
   logic                              final_res;

   modport source (output valid, output served_cylinder, output move_distance,
                   output total_seek, output overflow, output final_res,
                   input ready);
   modport sink   (input valid, input served_cylinder, input move_distance,
                   input total_seek, input overflow, input final_res,
                   output ready);
endinterface

// File: rtl/sstf_cell.sv
// ---------------------------------------------------------------------------
// SSTF storage cell
// Holds one request; shifts from its neighbor on load or ring rotation.
// ---------------------------------------------------------------------------
module sstf_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  sstf_pkg::cell_ctl_type  ctl,
   input  sstf_pkg::cell_data_type nbr,
   output sstf_pkg::cell_data_type data
);

   logic [sstf_pkg::CYL_BITS-1:0] cyl_ff;
   logic [sstf_pkg::IDX_BITS-1:0] idx_ff;
   logic                          live_ff;
   logic                          live_in;

   always_comb begin
      if (ctl.clear) begin
         live_in = 1'b0;
      end else if (ctl.shift) begin
         live_in = nbr.live;
      end else if (ctl.mark && (idx_ff == ctl.mark_idx)) begin
         live_in = 1'b0;   // served, drop out of later sweeps
      end else begin
         live_in = live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         cyl_ff <= nbr.cyl;
         idx_ff <= nbr.idx;
      end
   end

   assign data.cyl  = cyl_ff;
   assign data.idx  = idx_ff;
   assign data.live = live_ff;

endmodule

// File: rtl/sstf_pick.sv
// ---------------------------------------------------------------------------
// SSTF nearest-request picker
// Watches the ring tap once per enabled cycle; keeps the nearest live entry.
// ---------------------------------------------------------------------------
module sstf_pick (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          start,
   input  logic [sstf_pkg::CYL_BITS-1:0] head,
   input  sstf_pkg::cell_data_type       tap,
   output sstf_pkg::best_type            best
);

   sstf_pkg::best_type            best_ff;
   sstf_pkg::best_type            best_in;
   logic [sstf_pkg::CYL_BITS-1:0] tap_dist;
   logic                          found_eff;
   logic                          take;

   assign tap_dist  = (tap.cyl >= head) ? (tap.cyl - head) : (head - tap.cyl);
   assign found_eff = best_ff.found && !start;
   // equal distance: lower load index wins
   assign take = tap.live &&
                 (!found_eff || (tap_dist < best_ff.distance) ||
                  ((tap_dist == best_ff.distance) && (tap.idx < best_ff.idx)));

   always_comb begin
      best_in = best_ff;
      if (enable) begin
         if (take) begin
            best_in.found    = 1'b1;
            best_in.distance = tap_dist;
            best_in.idx      = tap.idx;
            best_in.cyl      = tap.cyl;
         end else if (start) begin
            best_in.found = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.found <= 1'b0;
      end else begin
         best_ff.found <= best_in.found;
      end
      best_ff.distance <= best_in.distance;
      best_ff.idx      <= best_in.idx;
      best_ff.cyl      <= best_in.cyl;
   end

   assign best = best_ff;

endmodule

// File: rtl/sstf_disk_scheduler.sv
// ---------------------------------------------------------------------------
// SSTF disk scheduler
// Loads a batch of cylinder requests and serves them nearest-first.
// ---------------------------------------------------------------------------
// Load: one request transaction per cycle while idle; non-last requests
//   give no result. Serve: each result takes a full turn of the cell ring
//   past the picker tap, then a pick step that waits for a free result
//   register; the first turn starts once the last-marked request is taken.
// Reset is synchronous, active high; it clears control, count and flags,
//   start_head goes to zero, stored cylinders stay undefined until loaded.
// ---------------------------------------------------------------------------
module sstf_disk_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   sstf_req_if.sink                           req_if,
   sstf_rsp_if.source                         rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sstf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sstf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sstf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int N = sstf_pkg::MAX_REQUESTS;

   // ---------------- configuration ----------------
   logic [15:0] start_head_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= '0;
      end else if (csr_wr && (csr_paddr[2] == sstf_pkg::REG_START_HEAD)) begin
         start_head_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == sstf_pkg::REG_START_HEAD) ?
                       {{(sstf_pkg::CSR_DATA_BITS-16){1'b0}}, start_head_ff} : '0;

   // ---------------- control state ----------------
   sstf_pkg::state_type           state_ff, state_in;
   logic [sstf_pkg::CNT_BITS-1:0]  count_ff, count_in;     // stored requests
   logic [sstf_pkg::CNT_BITS-1:0]  served_ff, served_in;   // results issued
   logic [sstf_pkg::IDX_BITS-1:0]  sweep_ff, sweep_in;     // ring position
   logic                           dropped_ff, dropped_in;
   logic [sstf_pkg::CYL_BITS-1:0]  head_ff, head_in;
   logic [sstf_pkg::SEEK_BITS-1:0] seek_ff, seek_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sstf_pkg::OUT_CYL_BITS-1:0] rsp_cyl_ff, rsp_dist_ff;
   logic [sstf_pkg::SEEK_BITS-1:0]    rsp_seek_ff;
   logic                              rsp_ovf_ff, rsp_final_ff;

   logic                           req_acc;
   logic                           rsp_free;
   logic                           load_rsp;
   logic                           is_final;
   logic                           sweep_end;
   logic [sstf_pkg::SEEK_BITS:0]   seek_sum;

   sstf_pkg::cell_ctl_type         ctl;
   sstf_pkg::cell_data_type        chain [N];
   sstf_pkg::cell_data_type        tail_in;
   sstf_pkg::best_type             best;
   logic [N-1:0]                   live_vec;

   assign req_if.ready = (state_ff == sstf_pkg::ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign load_rsp     = (state_ff == sstf_pkg::ST_PICK) && rsp_free;
   assign is_final     = ((served_ff + 1'b1) == count_ff);
   assign sweep_end    = (sweep_ff == sstf_pkg::IDX_BITS'(N - 1));
   assign seek_sum     = {1'b0, seek_ff} + (sstf_pkg::SEEK_BITS + 1)'(best.distance);

   // ---------------- cell ring ----------------
   // Loading shifts the chain toward cell 0 with the new request entering at
   // the tail; cell 0 is never live then since count < MAX_REQUESTS.
   // Searching rotates cell 0 back into the tail, one full turn per pick.
   always_comb begin
      ctl.shift    = 1'b0;
      ctl.mark     = load_rsp;
      ctl.clear    = load_rsp && is_final;
      ctl.mark_idx = best.idx;
      if (req_acc && (count_ff < sstf_pkg::CNT_BITS'(N))) begin
         ctl.shift = 1'b1;
      end else if (state_ff == sstf_pkg::ST_SEARCH) begin
         ctl.shift = 1'b1;
      end
   end

   always_comb begin
      if (state_ff == sstf_pkg::ST_IDLE) begin
         tail_in.cyl  = req_if.cylinder[sstf_pkg::CYL_BITS-1:0];
         tail_in.idx  = count_ff[sstf_pkg::IDX_BITS-1:0];
         tail_in.live = 1'b1;
      end else begin
         tail_in = chain[0];
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_cell
      if (k == N - 1) begin : g_tail
         sstf_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .nbr   (tail_in),
            .data  (chain[k])
         );
      end else begin : g_body
         sstf_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .nbr   (chain[k+1]),
            .data  (chain[k])
         );
      end
      assign live_vec[k] = chain[k].live;
   end

   // nearest-entry search at the ring tap
   sstf_pick u_pick (
      .clock  (clock),
      .reset  (reset),
      .enable (state_ff == sstf_pkg::ST_SEARCH),
      .start  (sweep_ff == '0),
      .head   (head_ff),
      .tap    (chain[0]),
      .best   (best)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      served_in  = served_ff;
      sweep_in   = sweep_ff;
      dropped_in = dropped_ff;
      head_in    = head_ff;
      seek_in    = seek_ff;
      case (state_ff)
         sstf_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (count_ff < sstf_pkg::CNT_BITS'(N)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;   // batch full, request dropped
               end
               if (req_if.last) begin
                  head_in  = start_head_ff[sstf_pkg::CYL_BITS-1:0];
                  sweep_in = '0;
                  state_in = sstf_pkg::ST_SEARCH;
               end
            end
         end
         sstf_pkg::ST_SEARCH: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_end) begin
               sweep_in = '0;
               state_in = sstf_pkg::ST_PICK;
            end
         end
         sstf_pkg::ST_PICK: begin
            if (rsp_free) begin
               head_in   = best.cyl;
               seek_in   = seek_sum[sstf_pkg::SEEK_BITS] ? sstf_pkg::SEEK_MAX :
                           seek_sum[sstf_pkg::SEEK_BITS-1:0];
               served_in = served_ff + 1'b1;
               state_in  = sstf_pkg::ST_SEARCH;
               if (is_final) begin
                  // batch done: clear batch state
                  count_in   = '0;
                  served_in  = '0;
                  dropped_in = 1'b0;
                  seek_in    = '0;
                  state_in   = sstf_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sstf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sstf_pkg::ST_IDLE;
         count_ff   <= '0;
         served_ff  <= '0;
         sweep_ff   <= '0;
         dropped_ff <= 1'b0;
         head_ff    <= '0;
         seek_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         served_ff  <= served_in;
         sweep_ff   <= sweep_in;
         dropped_ff <= dropped_in;
         head_ff    <= head_in;
         seek_ff    <= seek_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_cyl_ff   <= sstf_pkg::OUT_CYL_BITS'(best.cyl);
         rsp_dist_ff  <= sstf_pkg::OUT_CYL_BITS'(best.distance);
         rsp_seek_ff  <= seek_sum[sstf_pkg::SEEK_BITS] ? sstf_pkg::SEEK_MAX :
                         seek_sum[sstf_pkg::SEEK_BITS-1:0];
         rsp_ovf_ff   <= dropped_ff;
         rsp_final_ff <= is_final;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.served_cylinder = rsp_cyl_ff;
   assign rsp_if.move_distance   = rsp_dist_ff;
   assign rsp_if.total_seek      = rsp_seek_ff;
   assign rsp_if.overflow        = rsp_ovf_ff;
   assign rsp_if.final_res       = rsp_final_ff;

   // ---------------- assertions ----------------
   // live cells always equal stored minus served requests
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(live_vec) == (int'(count_ff) - int'(served_ff)))
      else $error("live cell count out of step with batch counters");

   // a full sweep always finds an unserved request
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstf_pkg::ST_PICK) |-> best.found)
      else $error("pick without a candidate");

   // serving never runs past the stored count
   a_served_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sstf_pkg::ST_IDLE) |-> (served_ff < count_ff))
      else $error("served count reached stored count while serving");

   // final result empties the batch
   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && is_final) |=> ((count_ff == '0) && (live_vec == '0)))
      else $error("batch not cleared after final result");

endmodule

// File: tb/sv/sstf_serve_checker.sv
// ---------------------------------------------------------------------------
// SSTF serve checker
// Watches the request, result and CSR ports of the scheduler. Keeps its own
// copy of the batch and works out the nearest-first serve order on each
// last-marked request, then compares every result transaction against it.
// ---------------------------------------------------------------------------
module sstf_serve_checker (
   input  logic                               clock,
   input  logic                               reset,
   sstf_req_if                                req_if,
   sstf_rsp_if                                rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sstf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sstf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                               csr_pready,
   output int unsigned                        fail_count,
   output int unsigned                        pending_results
);

   typedef struct packed {
      logic [sstf_pkg::OUT_CYL_BITS-1:0] cyl;
      logic [sstf_pkg::OUT_CYL_BITS-1:0] distance;
      logic [sstf_pkg::SEEK_BITS-1:0]    seek;
      logic                              ovf;
      logic                              fin;
   } serve_result_type;

   logic [sstf_pkg::OUT_CYL_BITS-1:0] head_cfg;
   logic [sstf_pkg::CYL_BITS-1:0]     stored_cyl [sstf_pkg::MAX_REQUESTS];
   int unsigned                       batch_len;
   bit                                batch_dropped;
   serve_result_type                  expected_serves [$];

   // nearest-first order over the stored batch; ties go to the earlier load
   task automatic serve_nearest_first();
      logic [sstf_pkg::CYL_BITS-1:0]  head;
      logic [sstf_pkg::CYL_BITS-1:0]  d;
      logic [sstf_pkg::CYL_BITS-1:0]  best_dist;
      logic [sstf_pkg::SEEK_BITS:0]   sum;
      int unsigned                    best;
      bit                             found;
      bit                             taken [sstf_pkg::MAX_REQUESTS];
      serve_result_type               r;
      head = head_cfg;
      sum  = '0;
      for (int i = 0; i < sstf_pkg::MAX_REQUESTS; i++) taken[i] = 1'b0;
      for (int k = 0; k < batch_len; k++) begin
         found     = 1'b0;
         best      = 0;
         best_dist = '0;
         for (int i = 0; i < batch_len; i++) begin
            if (!taken[i]) begin
               d = (stored_cyl[i] >= head) ? stored_cyl[i] - head : head - stored_cyl[i];
               if (!found || d < best_dist) begin
                  found     = 1'b1;
                  best      = i;
                  best_dist = d;
               end
            end
         end
         taken[best] = 1'b1;
         head = stored_cyl[best];
         sum  = sum + (sstf_pkg::SEEK_BITS + 1)'(best_dist);
         if (sum > {1'b0, sstf_pkg::SEEK_MAX}) sum = {1'b0, sstf_pkg::SEEK_MAX};
         r.cyl      = head;
         r.distance = best_dist;
         r.seek     = sum[sstf_pkg::SEEK_BITS-1:0];
         r.ovf      = batch_dropped;
         r.fin      = (k == batch_len - 1);
         expected_serves.push_back(r);
      end
      batch_len     = 0;
      batch_dropped = 1'b0;
   endtask

   task automatic take_request(input logic [sstf_pkg::CYL_BITS-1:0] cyl,
                               input logic is_last);
      if (batch_len < sstf_pkg::MAX_REQUESTS) begin
         stored_cyl[batch_len] = cyl;
         batch_len++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (is_last) serve_nearest_first();
   endtask

   task automatic check_serve();
      serve_result_type exp_r;
      if (expected_serves.size() == 0) begin
         $error("result with no expectation: served_cylinder %0d", rsp_if.served_cylinder);
         fail_count++;
      end else begin
         exp_r = expected_serves.pop_front();
         if (rsp_if.served_cylinder !== exp_r.cyl) begin
            $error("served_cylinder: expected %0d, actual %0d", exp_r.cyl,
                   rsp_if.served_cylinder);
            fail_count++;
         end
         if (rsp_if.move_distance !== exp_r.distance) begin
            $error("move_distance: expected %0d, actual %0d", exp_r.distance,
                   rsp_if.move_distance);
            fail_count++;
         end
         if (rsp_if.total_seek !== exp_r.seek) begin
            $error("total_seek: expected %0d, actual %0d", exp_r.seek, rsp_if.total_seek);
            fail_count++;
         end
         if (rsp_if.overflow !== exp_r.ovf) begin
            $error("overflow: expected %0d, actual %0d", exp_r.ovf, rsp_if.overflow);
            fail_count++;
         end
         if (rsp_if.final_res !== exp_r.fin) begin
            $error("final_res: expected %0d, actual %0d", exp_r.fin, rsp_if.final_res);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_cfg      = '0;
         batch_len     = 0;
         batch_dropped = 1'b0;
         fail_count    = 0;
         expected_serves.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == sstf_pkg::REG_START_HEAD)
            head_cfg = csr_pwdata[sstf_pkg::OUT_CYL_BITS-1:0];
         if (rsp_if.valid && rsp_if.ready) check_serve();
         if (req_if.valid && req_if.ready) take_request(req_if.cylinder, req_if.last);
      end
      pending_results = expected_serves.size();
   end

endmodule

// File: tb/sv/tb_sstf_disk_scheduler.sv
// ---------------------------------------------------------------------------
// SSTF disk scheduler testbench
// Drives request batches and start_head settings into the scheduler, with
// random gaps on the request side and random stalls on the result side.
// A checker beside the block predicts and compares; this top gives verdict.
// ---------------------------------------------------------------------------
module tb_sstf_disk_scheduler;

   // total request transactions to aim for
   localparam int ITEMS_TOTAL   = 430;
   // final stretch with no gaps and no stalls
   localparam int QUIET_ITEMS   = 60;
   // settle time covers a full turn of the cell ring and the pick after it
   localparam int SETTLE_CYCLES = sstf_pkg::MAX_REQUESTS + 8;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [sstf_pkg::CSR_ADDR_BITS-1:0] ADDR_START_HEAD =
      {sstf_pkg::REG_START_HEAD, 2'b00};
   localparam logic [sstf_pkg::CSR_ADDR_BITS-1:0] ADDR_UNMAPPED   =
      {~sstf_pkg::REG_START_HEAD, 2'b00};

   logic clock = 1'b0;
   logic reset;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [sstf_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [sstf_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [sstf_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;

   // idling enables for each side; both dropped for the last part of the run
   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;

   logic [sstf_pkg::CYL_BITS-1:0] batch_cyls [$];

   sstf_req_if req_ch ();
   sstf_rsp_if rsp_ch ();

   sstf_disk_scheduler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sstf_serve_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result-side backpressure: ready runs of random length, sometimes long,
   // broken by stall bursts of random length while stalls are enabled.
   // Each change of ready lands on its own falling edge.
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(60, 200)) @(negedge clock);
         else
            repeat ($urandom_range(1, 40)) @(negedge clock);
         if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // One request transaction. Entered and left at a falling edge; valid is
   // only lowered when a gap is inserted, so back-to-back items keep it high.
   task automatic send_request(input logic [sstf_pkg::CYL_BITS-1:0] cyl,
                               input logic is_last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cylinder <= cyl;
      req_ch.last     <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // whole batch from batch_cyls, last mark on the final entry
   task automatic send_batch();
      for (int i = 0; i < batch_cyls.size(); i++)
         send_request(batch_cyls[i], i == batch_cyls.size() - 1);
   endtask

   // APB write: setup then access, register taken at the access edge
   task automatic csr_write(input logic [sstf_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [sstf_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Block is idle once every predicted serve has come back and the
   // pipeline has had time to flush. The last request is withdrawn first
   // so it is not taken a second time once the block is idle again.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Cylinder picker. Mode 0: uniform over the full range. Mode 1: clustered
   // near the head so moves are short and ties are likely. Mode 2: a small
   // pool of edge values and the head, giving duplicates and max-length moves.
   function automatic logic [sstf_pkg::CYL_BITS-1:0] pick_cylinder(
         input int mode, input logic [sstf_pkg::CYL_BITS-1:0] near);
      logic [sstf_pkg::CYL_BITS-1:0] c;
      case (mode)
         0: c = sstf_pkg::CYL_BITS'($urandom);
         1: c = near + sstf_pkg::CYL_BITS'($urandom_range(0, 128))
                - sstf_pkg::CYL_BITS'(64);
         default: begin
            case ($urandom_range(0, 5))
               0: c = '0;
               1: c = '1;
               2: c = sstf_pkg::CYL_BITS'(1);
               3: c = {1'b1, {(sstf_pkg::CYL_BITS-1){1'b0}}};
               4: c = near;
               default: c = ~sstf_pkg::CYL_BITS'(1);
            endcase
         end
      endcase
      return c;
   endfunction

   initial begin
      logic [sstf_pkg::OUT_CYL_BITS-1:0]  head;
      logic [sstf_pkg::CSR_DATA_BITS-1:0] wdata;
      int                                 len;
      int                                 mode;
      bit                                 overflow_done;

      // every block input known from time zero
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cylinder = '0;
      req_ch.last     = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      overflow_done   = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // start_head still at its reset value of zero: single zero request,
      // then a duplicate at the top of the range plus its two lowest values
      batch_cyls = '{16'd0};
      send_batch();
      batch_cyls = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
      send_batch();

      // head at the top; upper data bits set to see they are dropped
      settle();
      csr_write(ADDR_START_HEAD, 32'hFFFF_FFFF);
      csr_write(ADDR_UNMAPPED, 32'h0000_1234);
      batch_cyls = '{16'd100, 16'hFFFF, 16'd0};
      send_batch();

      // equal distances on both sides of the head: earlier load must win
      settle();
      csr_write(ADDR_START_HEAD, 32'd1000);
      batch_cyls = '{16'd990, 16'd1010, 16'd1010, 16'd990, 16'd1000};
      send_batch();
      batch_cyls = '{16'd1000};
      send_batch();

      // write to an unmapped register must leave start_head alone
      settle();
      csr_write(ADDR_START_HEAD, 32'd32768);
      csr_write(ADDR_UNMAPPED, 32'hDEAD_0000);
      batch_cyls = '{16'd32767, 16'd32769, 16'h8000};
      send_batch();

      // ---- random part ----
      // phases of 1..4 batches, each phase under a fresh start_head;
      // the first batch overflows the store so the drop path is covered
      while (items_sent < ITEMS_TOTAL) begin
         if (items_sent >= ITEMS_TOTAL - QUIET_ITEMS) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         settle();
         case ($urandom_range(0, 3))
            0: head = '0;
            1: head = '1;
            default: head = sstf_pkg::OUT_CYL_BITS'($urandom);
         endcase
         wdata = $urandom;
         wdata[sstf_pkg::OUT_CYL_BITS-1:0] = head;
         csr_write(ADDR_START_HEAD, wdata);
         if ($urandom_range(0, 4) == 0) csr_write(ADDR_UNMAPPED, $urandom);

         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1: len = $urandom_range(7, sstf_pkg::MAX_REQUESTS);
               2:    len = $urandom_range(sstf_pkg::MAX_REQUESTS + 1,
                                          sstf_pkg::MAX_REQUESTS + 8);
               default: len = $urandom_range(1, 6);
            endcase
            if (!overflow_done) begin
               len = $urandom_range(sstf_pkg::MAX_REQUESTS + 1,
                                    sstf_pkg::MAX_REQUESTS + 8);
               overflow_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            batch_cyls.delete();
            repeat (len) batch_cyls.push_back(pick_cylinder(mode, head));
            send_batch();
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_results == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/sstf_pkg.sv
rtl/sstf_req_if.sv
rtl/sstf_rsp_if.sv
rtl/sstf_cell.sv
rtl/sstf_pick.sv
rtl/sstf_disk_scheduler.sv
tb/sv/sstf_serve_checker.sv
tb/sv/tb_sstf_disk_scheduler.sv
